// File: hdl/srp_pkg.sv
// Shared types, constants and codes for the skyline rectangle packer.
package srp_pkg;

	localparam int MAX_SEGMENTS = 64;
	localparam int COORD_BITS   = 15;
	localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
	localparam int COV_W        = COORD_BITS + 1;
	localparam int POS_W        = COORD_BITS - 1;
	localparam int ALLOC_W      = 16;
	localparam int CFG_IDX_W    = 2;

	localparam logic [COORD_BITS-1:0] ATLAS_LIMIT = COORD_BITS'(1 << (COORD_BITS - 1));
	localparam logic [COORD_BITS-1:0] ATLAS_RESET = COORD_BITS'(4096);

	localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ATLAS_HEIGHT = CFG_IDX_W'(1);

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_SIZE  = 2'd1,
		ST_NO_ROOM   = 2'd2,
		ST_STORE_FULL = 2'd3
	} status_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] left;
		logic [COORD_BITS-1:0] height;
		logic [COORD_BITS-1:0] span;
	} seg_t;

	typedef struct packed {
		logic valid;
		seg_t seg;
	} strm_t;

	typedef struct packed {
		logic                  ok;
		logic [COORD_BITS-1:0] top;
		logic [CNT_W-1:0]      cnt;
		logic [COV_W-1:0]      cov;
	} res_t;

	typedef enum logic [2:0] {
		C_NOP    = 3'd0,
		C_LOAD   = 3'd1,
		C_SEARCH = 3'd2,
		C_QUAL   = 3'd3,
		C_RSHIFT = 3'd4,
		C_SSHIFT = 3'd5,
		C_SH_DN  = 3'd6,
		C_SH_UP  = 3'd7
	} cell_op_t;

	typedef struct packed {
		cell_op_t              op;
		logic [COORD_BITS-1:0] tw;
		logic [COORD_BITS-1:0] th;
		logic [COORD_BITS-1:0] ah;
		logic [CNT_W-1:0]      n;
		logic [CNT_W-1:0]      dst;
		logic                  wr0_en;
		logic [CNT_W-1:0]      wr0_idx;
		seg_t                  wr0_seg;
		logic                  wr1_en;
		logic [CNT_W-1:0]      wr1_idx;
		seg_t                  wr1_seg;
	} cell_ctl_t;

endpackage

// File: hdl/srp_ifs.sv
// Handshake channel interfaces: request, result and register write.
interface srp_in_if;
	import srp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  mode;
	logic [COORD_BITS-1:0] tile_width;
	logic [COORD_BITS-1:0] tile_height;
	modport source (output valid, mode, tile_width, tile_height, input ready);
	modport sink   (input valid, mode, tile_width, tile_height, output ready);
endinterface

interface srp_out_if;
	import srp_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [POS_W-1:0]   place_x;
	logic [POS_W-1:0]   place_y;
	logic [ALLOC_W-1:0] allocation_count;
	modport source (output valid, status, place_x, place_y, allocation_count, input ready);
	modport sink   (input valid, status, place_x, place_y, allocation_count, output ready);
endinterface

interface srp_cfg_if;
	import srp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [COORD_BITS-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/srp_cell.sv
// One skyline cell: stored segment, streaming copy and fit accumulator.
module srp_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [srp_pkg::CNT_W-1:0] idx,
	input  srp_pkg::cell_ctl_t ctl,
	input  srp_pkg::seg_t      home_l,
	input  srp_pkg::seg_t      home_r,
	input  srp_pkg::strm_t     strm_r,
	input  srp_pkg::res_t      res_r,
	output srp_pkg::seg_t      home,
	output srp_pkg::strm_t     strm,
	output srp_pkg::res_t      res
);
	import srp_pkg::*;

	seg_t  home_q;
	strm_t strm_q;
	res_t  res_q;
	logic  fin;
	logic  in_list;

	assign fin     = res_q.cov >= {1'b0, ctl.tw};
	assign in_list = idx < ctl.n;

	// segment store: shifts and writes never share a cycle
	always_ff @(posedge clk) begin
		case (ctl.op)
			C_SH_DN: if (idx >= ctl.dst) home_q <= home_r;
			C_SH_UP: if (idx >= ctl.dst) home_q <= home_l;
			default: ;
		endcase
		if (ctl.wr0_en && idx == ctl.wr0_idx) home_q <= ctl.wr0_seg;
		if (ctl.wr1_en && idx == ctl.wr1_idx) home_q <= ctl.wr1_seg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strm_q <= '0;
			res_q  <= '0;
		end else begin
			case (ctl.op)
				C_LOAD: begin
					strm_q.valid <= in_list;
					strm_q.seg   <= home_q;
					res_q        <= '0;
				end
				C_SEARCH: begin
					strm_q <= strm_r;
					if (!fin && strm_q.valid) begin
						if (strm_q.seg.height > res_q.top) res_q.top <= strm_q.seg.height;
						res_q.cov <= res_q.cov + {1'b0, strm_q.seg.span};
						res_q.cnt <= res_q.cnt + CNT_W'(1);
					end
				end
				C_QUAL: begin
					res_q.ok <= in_list && fin &&
						(({1'b0, res_q.top} + {1'b0, ctl.th}) <= {1'b0, ctl.ah});
				end
				C_RSHIFT: res_q  <= res_r;
				C_SSHIFT: strm_q <= strm_r;
				default: ;
			endcase
		end
	end

	assign home = home_q;
	assign strm = strm_q;
	assign res  = res_q;

endmodule

// File: hdl/skyline_rect_packer_top.sv
// Top level of the skyline rectangle packer: cell row and sequencer.
//
// Usage:
//  - in_ch: one beat per request. mode 0 allocates a tile of tile_width by
//    tile_height, mode 1 clears the atlas to one flat segment.
//  - out_ch: exactly one result beat per request (status, place_x, place_y,
//    allocation_count), in request order.
//  - cfg_ch: register writes (index 0 atlas_width, 1 atlas_height), always
//    ready; values above 16384 saturate. Write only while idle.
// Sequence: clear, bad size and empty skyline go from idle straight to the
//  done state. A full allocate for n segments in the skyline runs n search
//  steps, n select steps, n gather steps and up to n single-position shifts
//  of the segment row. The cell row steps one position per cycle.
// One request is in work at a time; the next is accepted as soon as the
//  sequencer is idle, even while the last result still waits in the output
//  register. If the receiver stalls, a finished result waits for it.
// Reset: skyline empty (allocates answer no room until the first clear),
//  allocation count zero, atlas registers 4096 by 4096.
module skyline_rect_packer_top (
	input logic     clk,
	input logic     arst_n,
	srp_in_if.sink  in_ch,
	srp_out_if.source out_ch,
	srp_cfg_if.sink cfg_ch
);
	import srp_pkg::*;

	localparam int EW = CNT_W + 1;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_SEARCH = 10'b0000000010,
		S_QUAL   = 10'b0000000100,
		S_SELECT = 10'b0000001000,
		S_GLOAD  = 10'b0000010000,
		S_GATHER = 10'b0000100000,
		S_CALC   = 10'b0001000000,
		S_SHIFT  = 10'b0010000000,
		S_WRITE  = 10'b0100000000,
		S_DONE   = 10'b1000000000
	} state_t;

	state_t state_q;

	// registers
	logic [COORD_BITS-1:0] aw_q, ah_q;
	logic [CNT_W-1:0]      n_q;
	logic [ALLOC_W-1:0]    alloc_q;
	logic [COORD_BITS-1:0] tw_q, th_q;
	logic [CNT_W-1:0]      k_q;

	// best candidate
	logic                  found_q;
	logic [CNT_W-1:0]      b_q;
	logic [COORD_BITS-1:0] by_q;
	logic [CNT_W-1:0]      bcnt_q;
	logic [COV_W-1:0]      bcov_q;

	// gathered neighbours
	logic [COORD_BITS-1:0] nx_q, pl_l_q, pl_h_q, pl_s_q, ph_q, rh_q, rs_q;
	logic                  rv_q;

	// rewrite plan
	logic [CNT_W-1:0]      nn_q, dst_q, shc_q, q_q;
	logic                  up_q, p_q;
	seg_t                  w0_q, w1_q;

	// result
	status_t               rst_q;
	logic [POS_W-1:0]      rx_q, ry_q;
	logic                  out_v_q;
	logic [1:0]            o_status_q;
	logic [POS_W-1:0]      o_x_q, o_y_q;
	logic [ALLOC_W-1:0]    o_cnt_q;

	cell_ctl_t ctl;
	seg_t      home_a [MAX_SEGMENTS];
	strm_t     strm_a [MAX_SEGMENTS];
	res_t      res_a  [MAX_SEGMENTS];

	genvar gi;
	generate
		for (gi = 0; gi < MAX_SEGMENTS; gi++) begin : g_cell
			seg_t  hl, hr;
			strm_t sr;
			res_t  rr;
			if (gi == 0) begin : g_first
				assign hl = '0;
			end else begin : g_mid_l
				assign hl = home_a[gi-1];
			end
			if (gi == MAX_SEGMENTS - 1) begin : g_last
				assign hr = '0;
				assign sr = '0;
				assign rr = '0;
			end else begin : g_mid_r
				assign hr = home_a[gi+1];
				assign sr = strm_a[gi+1];
				assign rr = res_a[gi+1];
			end
			srp_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.idx    (CNT_W'(gi)),
				.ctl    (ctl),
				.home_l (hl),
				.home_r (hr),
				.strm_r (sr),
				.res_r  (rr),
				.home   (home_a[gi]),
				.strm   (strm_a[gi]),
				.res    (res_a[gi])
			);
		end
	endgenerate

	// handshakes
	logic in_acc, out_free, last_k, size_bad;
	assign in_ch.ready  = (state_q == S_IDLE);
	assign in_acc       = in_ch.valid && in_ch.ready;
	assign out_free     = !out_v_q || out_ch.ready;
	assign cfg_ch.ready = 1'b1;
	assign last_k       = (k_q == n_q - CNT_W'(1));
	assign size_bad     = (in_ch.tile_width == '0) || (in_ch.tile_height == '0) ||
		(in_ch.tile_width > aw_q) || (in_ch.tile_height > ah_q);

	logic [COORD_BITS-1:0] cfg_sat;
	assign cfg_sat = (cfg_ch.data > ATLAS_LIMIT) ? ATLAS_LIMIT : cfg_ch.data;

	// head of the row seen during select and gather
	res_t  head_res;
	strm_t head_strm;
	assign head_res  = res_a[0];
	assign head_strm = strm_a[0];

	// rewrite plan from the gathered values
	logic [COORD_BITS-1:0] nh;
	logic                  p_c, lm_c, rm_c, up_c;
	logic [EW-1:0]         b_e, cnt_e, nn_c, q_c, dst_c, src_c, d_c, k_e;
	assign nh    = by_q + th_q;
	assign p_c   = bcov_q > {1'b0, tw_q};
	assign lm_c  = (b_q != '0) && (pl_h_q == nh);
	assign rm_c  = !p_c && rv_q && (rh_q == nh);
	assign b_e   = {1'b0, b_q};
	assign cnt_e = {1'b0, bcnt_q};
	assign k_e   = {1'b0, k_q};
	assign nn_c  = {1'b0, n_q} + EW'(1) + EW'(p_c) - cnt_e - EW'(lm_c) - EW'(rm_c);
	assign q_c   = b_e - EW'(lm_c);
	assign dst_c = q_c + EW'(1) + EW'(p_c);
	assign src_c = b_e + cnt_e + EW'(rm_c);
	assign up_c  = src_c < dst_c;
	assign d_c   = src_c - dst_c;

	// cell control
	always_comb begin
		ctl         = '0;
		ctl.op      = C_NOP;
		ctl.tw      = tw_q;
		ctl.th      = th_q;
		ctl.ah      = ah_q;
		ctl.n       = n_q;
		ctl.dst     = dst_q;
		ctl.wr0_idx = q_q;
		ctl.wr0_seg = w0_q;
		ctl.wr1_idx = q_q + CNT_W'(1);
		ctl.wr1_seg = w1_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc && in_ch.mode == MODE_CLEAR) begin
					// flat empty skyline in cell 0
					ctl.wr0_en      = (aw_q != '0) && (ah_q != '0);
					ctl.wr0_idx     = '0;
					ctl.wr0_seg     = '{left: '0, height: '0, span: aw_q};
				end else if (in_acc && !size_bad && n_q != '0) begin
					ctl.op = C_LOAD;
				end
			end
			S_SEARCH: ctl.op = C_SEARCH;
			S_QUAL:   ctl.op = C_QUAL;
			S_SELECT: ctl.op = C_RSHIFT;
			S_GLOAD:  ctl.op = C_LOAD;
			S_GATHER: ctl.op = C_SSHIFT;
			S_SHIFT:  ctl.op = up_q ? C_SH_UP : C_SH_DN;
			S_WRITE: begin
				ctl.wr0_en = 1'b1;
				ctl.wr1_en = p_q;
			end
			default: ;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_q <= ATLAS_RESET;
			ah_q <= ATLAS_RESET;
		end else if (cfg_ch.valid) begin
			if (cfg_ch.index == REG_ATLAS_WIDTH)  aw_q <= cfg_sat;
			if (cfg_ch.index == REG_ATLAS_HEIGHT) ah_q <= cfg_sat;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
			alloc_q <= '0;
			k_q     <= '0;
			found_q <= 1'b0;
			rv_q    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			// in S_DONE a free output register is reloaded below
			if (out_v_q && out_ch.ready && state_q != S_DONE) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						tw_q  <= in_ch.tile_width;
						th_q  <= in_ch.tile_height;
						rx_q  <= '0;
						ry_q  <= '0;
						k_q   <= '0;
						if (in_ch.mode == MODE_CLEAR) begin
							rst_q   <= ST_OK;
							alloc_q <= '0;
							n_q     <= ((aw_q != '0) && (ah_q != '0)) ? CNT_W'(1) : '0;
							state_q <= S_DONE;
						end else if (size_bad) begin
							rst_q   <= ST_BAD_SIZE;
							state_q <= S_DONE;
						end else if (n_q == '0) begin
							rst_q   <= ST_NO_ROOM;
							state_q <= S_DONE;
						end else begin
							rst_q   <= ST_OK;
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					k_q <= k_q + CNT_W'(1);
					if (last_k) state_q <= S_QUAL;
				end
				S_QUAL: begin
					k_q     <= '0;
					found_q <= 1'b0;
					state_q <= S_SELECT;
				end
				S_SELECT: begin
					// lowest resting height, first on ties
					if (head_res.ok && (!found_q || head_res.top < by_q)) begin
						found_q <= 1'b1;
						b_q     <= k_q;
						by_q    <= head_res.top;
						bcnt_q  <= head_res.cnt;
						bcov_q  <= head_res.cov;
					end
					k_q <= k_q + CNT_W'(1);
					if (last_k) state_q <= S_GLOAD;
				end
				S_GLOAD: begin
					k_q  <= '0;
					rv_q <= 1'b0;
					if (!found_q) begin
						rst_q   <= ST_NO_ROOM;
						state_q <= S_DONE;
					end else begin
						state_q <= S_GATHER;
					end
				end
				S_GATHER: begin
					if (k_e + EW'(1) == b_e) begin
						pl_l_q <= head_strm.seg.left;
						pl_h_q <= head_strm.seg.height;
						pl_s_q <= head_strm.seg.span;
					end
					if (k_q == b_q) nx_q <= head_strm.seg.left;
					if (k_e + EW'(1) == b_e + cnt_e) ph_q <= head_strm.seg.height;
					if (k_e == b_e + cnt_e) begin
						rv_q <= 1'b1;
						rh_q <= head_strm.seg.height;
						rs_q <= head_strm.seg.span;
					end
					k_q <= k_q + CNT_W'(1);
					if (last_k) state_q <= S_CALC;
				end
				S_CALC: begin
					nn_q  <= CNT_W'(nn_c);
					q_q   <= CNT_W'(q_c);
					dst_q <= CNT_W'(dst_c);
					up_q  <= up_c;
					p_q   <= p_c;
					shc_q <= up_c ? CNT_W'(1) : CNT_W'(d_c);
					w0_q.left   <= lm_c ? pl_l_q : nx_q;
					w0_q.height <= nh;
					w0_q.span   <= tw_q + (lm_c ? pl_s_q : '0) + (rm_c ? rs_q : '0);
					w1_q.left   <= nx_q + tw_q;
					w1_q.height <= ph_q;
					w1_q.span   <= COORD_BITS'(bcov_q - {1'b0, tw_q});
					if (nn_c > EW'(MAX_SEGMENTS)) begin
						rst_q   <= ST_STORE_FULL;
						state_q <= S_DONE;
					end else if (!up_c && d_c == '0) begin
						state_q <= S_WRITE;
					end else begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					shc_q <= shc_q - CNT_W'(1);
					if (shc_q == CNT_W'(1)) state_q <= S_WRITE;
				end
				S_WRITE: begin
					n_q     <= nn_q;
					alloc_q <= alloc_q + ALLOC_W'(1);
					rx_q    <= nx_q[POS_W-1:0];
					ry_q    <= by_q[POS_W-1:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result beat register
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			o_status_q <= rst_q;
			o_x_q      <= rx_q;
			o_y_q      <= ry_q;
			o_cnt_q    <= alloc_q;
		end
	end

	assign out_ch.valid            = out_v_q;
	assign out_ch.status           = o_status_q;
	assign out_ch.place_x          = o_x_q;
	assign out_ch.place_y          = o_y_q;
	assign out_ch.allocation_count = o_cnt_q;

endmodule
